[rtl/rpm_pkg.sv]
// shared constants, command and status types and helpers of the three-phase rms power meter
package rpm_pkg;

	// sample and window sizes
	localparam int SAMPLE_BITS = 16;
	localparam int WINDOW_MAX  = 4096;
	localparam int CFG_W       = 13;
	localparam int COUNT_W     = 13;
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

	// accumulator widths
	localparam int PHASE_W = 43;
	localparam int LINE_W  = 45;
	localparam int POWER_W = 43;
	localparam int RESID_W = 46;
	localparam int TOTAL_W = POWER_W + 2;
	localparam int ACC_W   = 48;
	localparam int NUM_ACC = 14;

	// multiplier operands: phase, line and residual values fit sample width plus two
	localparam int OPND_W = SAMPLE_BITS + 2;
	localparam int PROD_W = 2 * OPND_W;

	// divide and square root units
	localparam int DIV_W  = 46;
	localparam int ROOT_W = DIV_W / 2;

	// result codes
	localparam int ID_W = 4;
	typedef logic [ID_W-1:0] idx_t;

	localparam idx_t ID_VRMS_A  = 4'd0;
	localparam idx_t ID_VRMS_B  = 4'd1;
	localparam idx_t ID_VRMS_C  = 4'd2;
	localparam idx_t ID_IRMS_A  = 4'd3;
	localparam idx_t ID_IRMS_B  = 4'd4;
	localparam idx_t ID_IRMS_C  = 4'd5;
	localparam idx_t ID_VRMS_AB = 4'd6;
	localparam idx_t ID_VRMS_BC = 4'd7;
	localparam idx_t ID_VRMS_CA = 4'd8;
	localparam idx_t ID_POWER_A = 4'd9;
	localparam idx_t ID_POWER_B = 4'd10;
	localparam idx_t ID_POWER_C = 4'd11;
	localparam idx_t ID_TOTAL   = 4'd12;
	localparam idx_t ID_RESID_V = 4'd13;
	localparam idx_t ID_RESID_I = 4'd14;

	// accumulator slots, also the multiply steps of one sample
	localparam idx_t ACC_VA = 4'd0;
	localparam idx_t ACC_VB = 4'd1;
	localparam idx_t ACC_VC = 4'd2;
	localparam idx_t ACC_IA = 4'd3;
	localparam idx_t ACC_IB = 4'd4;
	localparam idx_t ACC_IC = 4'd5;
	localparam idx_t ACC_AB = 4'd6;
	localparam idx_t ACC_BC = 4'd7;
	localparam idx_t ACC_CA = 4'd8;
	localparam idx_t ACC_PA = 4'd9;
	localparam idx_t ACC_PB = 4'd10;
	localparam idx_t ACC_PC = 4'd11;
	localparam idx_t ACC_RV = 4'd12;
	localparam idx_t ACC_RI = 4'd13;

	// controller to datapath commands
	typedef struct packed {
		logic take_sample;
		logic mul;
		logic acc;
		logic count;
		logic load;
		logic div_take;
		logic sqrt_take;
		logic clear;
		idx_t idx;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic close_win;
		logic div_busy;
		logic sqrt_busy;
	} dp_status_t;

	// wrap mask of each accumulator slot
	function automatic logic [ACC_W-1:0] acc_mask(idx_t i);
		logic [ACC_W-1:0] m;
		case (i) inside
			ACC_VA, ACC_VB, ACC_VC, ACC_IA, ACC_IB, ACC_IC:
				m = {{(ACC_W-PHASE_W){1'b0}}, {PHASE_W{1'b1}}};
			ACC_AB, ACC_BC, ACC_CA:
				m = {{(ACC_W-LINE_W){1'b0}}, {LINE_W{1'b1}}};
			ACC_PA, ACC_PB, ACC_PC:
				m = {{(ACC_W-POWER_W){1'b0}}, {POWER_W{1'b1}}};
			ACC_RV, ACC_RI:
				m = {{(ACC_W-RESID_W){1'b0}}, {RESID_W{1'b1}}};
			default:
				m = '0;
		endcase
		return m;
	endfunction

	// result goes through the square root
	function automatic logic is_rms(idx_t i);
		return i <= ID_VRMS_CA;
	endfunction

	// result is a raw residual sum
	function automatic logic is_raw(idx_t i);
		return (i == ID_RESID_V) || (i == ID_RESID_I);
	endfunction

	// accumulator slot read for a result
	function automatic idx_t acc_of(idx_t i);
		idx_t a;
		a = is_raw(i) ? idx_t'(i - 1'b1) : i;
		return a;
	endfunction

endpackage

[rtl/rpm_div.sv]
// iterative restoring divider, one quotient bit per cycle
module rpm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rpm_pkg::DIV_W-1:0]   dividend,
	input  logic [rpm_pkg::COUNT_W-1:0] divisor,
	output logic                        busy,
	output logic [rpm_pkg::DIV_W-1:0]   quotient
);
	import rpm_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0]   quo_q;
	logic [COUNT_W-1:0] rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [COUNT_W:0]   part;
	logic [COUNT_W:0]   diff;
	logic               fits;

	// trial subtract of the divisor
	always_comb begin
		part = {rem_q, quo_q[DIV_W-1]};
		fits = part >= {1'b0, divisor};
		diff = part - {1'b0, divisor};
	end

	// iteration count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIV_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// dividend shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[COUNT_W-1:0] : part[COUNT_W-1:0];
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = quo_q;

endmodule

[rtl/rpm_sqrt.sv]
// digit-by-digit floor square root, one root bit per cycle
module rpm_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rpm_pkg::DIV_W-1:0]  radicand,
	output logic                       busy,
	output logic [rpm_pkg::ROOT_W-1:0] root
);
	import rpm_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [DIV_W-1:0]  rad_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ROOT_W+1:0] part;
	logic [ROOT_W+1:0] trial;
	logic [ROOT_W+1:0] diff;
	logic              fits;

	// bring down two radicand bits and try root*4+1
	always_comb begin
		part  = {rem_q, rad_q[DIV_W-1 -: 2]};
		trial = {root_q, 2'b01};
		fits  = part >= trial;
		diff  = part - trial;
	end

	// iteration count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(ROOT_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// root and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= {rad_q[DIV_W-3:0], 2'b00};
			root_q <= {root_q[ROOT_W-2:0], fits};
			rem_q  <= fits ? diff[ROOT_W-1:0] : part[ROOT_W-1:0];
		end
	end

	assign busy = cnt_q != '0;
	assign root = root_q;

endmodule

[rtl/rpm_dp.sv]
// datapath: sample registers, shared multiplier, accumulators, window count and report math
module rpm_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [rpm_pkg::SAMPLE_BITS-1:0] volt_a,
	input  logic [rpm_pkg::SAMPLE_BITS-1:0] volt_b,
	input  logic [rpm_pkg::SAMPLE_BITS-1:0] volt_c,
	input  logic [rpm_pkg::SAMPLE_BITS-1:0] amp_a,
	input  logic [rpm_pkg::SAMPLE_BITS-1:0] amp_b,
	input  logic [rpm_pkg::SAMPLE_BITS-1:0] amp_c,
	input  logic                            cfg_we,
	input  logic [rpm_pkg::CFG_W-1:0]       cfg_data,
	input  rpm_pkg::dp_cmd_t                cmd,
	output rpm_pkg::dp_status_t             status,
	output logic [rpm_pkg::ACC_W-1:0]       result
);
	import rpm_pkg::*;

	logic signed [SAMPLE_BITS-1:0] volt_q [3];
	logic signed [SAMPLE_BITS-1:0] amp_q  [3];
	logic signed [OPND_W-1:0]      va, vb, vc, ia, ib, ic;
	logic signed [OPND_W-1:0]      opnd_a, opnd_b;
	logic signed [PROD_W-1:0]      mul_s1;
	logic [ACC_W-1:0]              acc_q [NUM_ACC];
	logic [ACC_W-1:0]              rd;
	logic [ACC_W-1:0]              acc_sum;
	idx_t                          rd_addr;
	logic [CFG_W-1:0]              cfg_q;
	logic [CFG_W-1:0]              win_eff;
	logic [COUNT_W-1:0]            count_q;
	logic [COUNT_W-1:0]            count_next;
	logic signed [TOTAL_W-1:0]     total_q;
	logic signed [DIV_W-1:0]       sel_signed;
	logic [DIV_W-1:0]              div_in;
	logic                          neg;
	logic                          neg_q;
	logic [ACC_W-1:0]              result_q;
	logic                          div_start;
	logic                          sqrt_start;
	logic [DIV_W-1:0]              quo;
	logic [ROOT_W-1:0]             root;
	logic                          div_busy;
	logic                          sqrt_busy;

	// sample capture
	always_ff @(posedge clk) begin
		if (cmd.take_sample) begin
			volt_q[0] <= volt_a;
			volt_q[1] <= volt_b;
			volt_q[2] <= volt_c;
			amp_q[0]  <= amp_a;
			amp_q[1]  <= amp_b;
			amp_q[2]  <= amp_c;
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		va = OPND_W'(volt_q[0]);
		vb = OPND_W'(volt_q[1]);
		vc = OPND_W'(volt_q[2]);
		ia = OPND_W'(amp_q[0]);
		ib = OPND_W'(amp_q[1]);
		ic = OPND_W'(amp_q[2]);
		unique case (cmd.idx)
			ACC_VA:  begin opnd_a = va;           opnd_b = va;           end
			ACC_VB:  begin opnd_a = vb;           opnd_b = vb;           end
			ACC_VC:  begin opnd_a = vc;           opnd_b = vc;           end
			ACC_IA:  begin opnd_a = ia;           opnd_b = ia;           end
			ACC_IB:  begin opnd_a = ib;           opnd_b = ib;           end
			ACC_IC:  begin opnd_a = ic;           opnd_b = ic;           end
			ACC_AB:  begin opnd_a = va - vb;      opnd_b = va - vb;      end
			ACC_BC:  begin opnd_a = vb - vc;      opnd_b = vb - vc;      end
			ACC_CA:  begin opnd_a = vc - va;      opnd_b = vc - va;      end
			ACC_PA:  begin opnd_a = va;           opnd_b = ia;           end
			ACC_PB:  begin opnd_a = vb;           opnd_b = ib;           end
			ACC_PC:  begin opnd_a = vc;           opnd_b = ic;           end
			ACC_RV:  begin opnd_a = va + vb + vc; opnd_b = va + vb + vc; end
			ACC_RI:  begin opnd_a = ia + ib + ic; opnd_b = ia + ib + ic; end
			default: begin opnd_a = '0;           opnd_b = '0;           end
		endcase
	end

	// product register
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			mul_s1 <= opnd_a * opnd_b;
		end
	end

	// one read port on the accumulators, shared by update and report
	always_comb begin
		rd_addr = cmd.load ? acc_of(cmd.idx) : cmd.idx;
		rd      = acc_q[rd_addr];
		acc_sum = (rd + ACC_W'(mul_s1)) & acc_mask(cmd.idx);
	end

	// accumulators wrap at their own widths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ACC; i++) begin
				acc_q[i] <= '0;
			end
		end else if (cmd.clear) begin
			for (int i = 0; i < NUM_ACC; i++) begin
				acc_q[i] <= '0;
			end
		end else if (cmd.acc) begin
			acc_q[cmd.idx] <= acc_sum;
		end
	end

	// window length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_data;
		end
	end

	// saturating sample count and window close test
	always_comb begin
		win_eff    = (cfg_q > CFG_W'(WINDOW_MAX)) ? CFG_W'(WINDOW_MAX) : cfg_q;
		count_next = (count_q == {COUNT_W{1'b1}}) ? count_q : count_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.count) begin
			count_q <= count_next;
		end
	end

	// running total of the three power sums over a report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.clear) begin
			total_q <= '0;
		end else if (cmd.load && (cmd.idx >= ID_POWER_A) && (cmd.idx <= ID_POWER_C)) begin
			total_q <= total_q + TOTAL_W'($signed(rd[POWER_W-1:0]));
		end
	end

	// divider operand: magnitude of the sum, sign kept for the quotient
	always_comb begin
		if (cmd.idx == ID_TOTAL) begin
			sel_signed = DIV_W'(total_q);
		end else begin
			sel_signed = DIV_W'($signed(rd[POWER_W-1:0]));
		end
		if (is_rms(cmd.idx)) begin
			neg    = 1'b0;
			div_in = rd[DIV_W-1:0];
		end else begin
			neg    = sel_signed[DIV_W-1];
			div_in = neg ? DIV_W'(-sel_signed) : DIV_W'(sel_signed);
		end
		div_start  = cmd.load && !is_raw(cmd.idx);
		sqrt_start = cmd.div_take && is_rms(cmd.idx);
	end

	rpm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_in),
		.divisor  (count_q),
		.busy     (div_busy),
		.quotient (quo)
	);

	rpm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (quo),
		.busy     (sqrt_busy),
		.root     (root)
	);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= neg;
			if (is_raw(cmd.idx)) begin
				result_q <= rd;
			end
		end else if (cmd.div_take && !is_rms(cmd.idx)) begin
			result_q <= neg_q ? ACC_W'(-{2'b00, quo}) : {2'b00, quo};
		end else if (cmd.sqrt_take) begin
			result_q <= ACC_W'(root);
		end
	end

	assign result           = result_q;
	assign status.close_win = (win_eff != '0) && (count_next >= win_eff);
	assign status.div_busy  = div_busy;
	assign status.sqrt_busy = sqrt_busy;

endmodule

[rtl/rpm_ctrl.sv]
// controller: sequences the per-sample multiply steps and the window report
module rpm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                last,
	input  rpm_pkg::dp_status_t status,
	output rpm_pkg::dp_cmd_t    cmd
);
	import rpm_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_MUL   = 9'b000000010,
		S_ACC   = 9'b000000100,
		S_COUNT = 9'b000001000,
		S_LOAD  = 9'b000010000,
		S_DIV   = 9'b000100000,
		S_SQRT  = 9'b001000000,
		S_OUT   = 9'b010000000,
		S_CLEAR = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	idx_t   idx_q, idx_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cmd     = '0;
		cmd.idx = idx_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take_sample = 1'b1;
					idx_d           = ACC_VA;
					state_d         = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				if (idx_q == ACC_RI) begin
					state_d = S_COUNT;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = S_MUL;
				end
			end
			S_COUNT: begin
				cmd.count = 1'b1;
				if (status.close_win) begin
					idx_d   = ID_VRMS_A;
					state_d = S_LOAD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = is_raw(idx_q) ? S_OUT : S_DIV;
			end
			S_DIV: begin
				if (!status.div_busy) begin
					cmd.div_take = 1'b1;
					state_d      = is_rms(idx_q) ? S_SQRT : S_OUT;
				end
			end
			S_SQRT: begin
				if (!status.sqrt_busy) begin
					cmd.sqrt_take = 1'b1;
					state_d       = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_stall) begin
					if (idx_q == ID_RESID_I) begin
						state_d = S_CLEAR;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = S_LOAD;
					end
				end
			end
			S_CLEAR: begin
				cmd.clear = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and step registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= ACC_VA;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign last      = idx_q == ID_RESID_I;

endmodule

[rtl/three_phase_rms_power_meter.sv]
// top level of the three-phase rms and active power meter
// Takes one three-phase sample set per input transaction and adds its squares, line-to-line
// squares, per-phase products and squared residuals into fourteen accumulators. One shared
// 18x18 multiplier handles the fourteen products in turn, each with a multiply and an
// accumulate step. When the count reaches samples_per_window (values above 4096 act as 4096,
// 0 never closes), the block sends 15 result transactions in quantity_id order,
// last_of_window on the final one, then clears all sums. Each mean goes through a bit-serial
// divider, and each rms value through a further bit-serial square root. No new sample is
// taken until the report is done.
// samples_per_window is written through the cfg channel, which is always ready; write it
// only while the block is idle.
module three_phase_rms_power_meter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [rpm_pkg::SAMPLE_BITS-1:0] volt_a,
	input  logic [rpm_pkg::SAMPLE_BITS-1:0] volt_b,
	input  logic [rpm_pkg::SAMPLE_BITS-1:0] volt_c,
	input  logic [rpm_pkg::SAMPLE_BITS-1:0] amp_a,
	input  logic [rpm_pkg::SAMPLE_BITS-1:0] amp_b,
	input  logic [rpm_pkg::SAMPLE_BITS-1:0] amp_c,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [rpm_pkg::ID_W-1:0]        quantity_id,
	output logic [rpm_pkg::ACC_W-1:0]       quantity_value,
	output logic                            last_of_window,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rpm_pkg::CFG_W-1:0]       cfg_data
);
	import rpm_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	rpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.last      (last_of_window),
		.status    (status),
		.cmd       (cmd)
	);

	rpm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.volt_a   (volt_a),
		.volt_b   (volt_b),
		.volt_c   (volt_c),
		.amp_a    (amp_a),
		.amp_b    (amp_b),
		.amp_c    (amp_c),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status),
		.result   (quantity_value)
	);

	assign quantity_id = cmd.idx;

	// a taken sample keeps the input stalled while it is processed
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a sample transaction");

	// no sample is taken while a report is pending
	a_no_take_in_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open during a window report");

	// the window end marker sits only on the last quantity
	a_last_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_window |-> quantity_id == ID_RESID_I)
		else $error("last_of_window on a wrong quantity");

	// each further result passes through the load state before it is shown
	a_result_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_window |=> !out_valid)
		else $error("result shown again without a load");

endmodule

[tb/sv/tb.sv]
// testbench of the three-phase rms power meter: random and directed sample sets against a predictor
`timescale 1ns / 1ps

module tb;
	import rpm_pkg::*;

	localparam int CYCLE_LIMIT   = 2_500_000;
	localparam int SETTLE_CYCLES = 64;
	localparam int FLOOD_SAMPLES = 16;
	localparam int RANDOM_ITEMS  = 290;
	localparam int MAX_REPORTED  = 100;

	// predicts window reports from accepted sample sets and checks the results that come out
	class window_report_check;
		typedef struct {
			idx_t             id;
			logic [ACC_W-1:0] value;
			logic             last;
		} quantity_t;

		logic [CFG_W-1:0]   window_len;
		logic [COUNT_W-1:0] sample_cnt;
		logic [PHASE_W-1:0] phase_sq[6];
		logic [LINE_W-1:0]  line_sq[3];
		logic [POWER_W-1:0] power_acc[3];
		logic [RESID_W-1:0] resid_sq[2];
		quantity_t          pending[$];
		int unsigned        mismatch_cnt;
		int unsigned        report_cnt;
		int unsigned        quantity_cnt;
		int unsigned        sample_total;

		function new();
			window_len = CFG_RESET;
			clear_sums();
		endfunction

		function void clear_sums();
			sample_cnt = '0;
			foreach (phase_sq[i]) phase_sq[i] = '0;
			foreach (line_sq[i]) line_sq[i] = '0;
			foreach (power_acc[i]) power_acc[i] = '0;
			foreach (resid_sq[i]) resid_sq[i] = '0;
		endfunction

		function void note_window(logic [CFG_W-1:0] len);
			window_len = len;
		endfunction

		// floor square root of the mean
		function longint unsigned mean_rms(longint unsigned total, longint unsigned n);
			longint unsigned x;
			longint unsigned root;
			longint unsigned b;
			x = total / n;
			root = 0;
			b = 64'd1 << 62;
			while (b > x) b >>= 2;
			while (b != 0) begin
				if (x >= root + b) begin
					x -= root + b;
					root = (root >> 1) + b;
				end else begin
					root >>= 1;
				end
				b >>= 2;
			end
			return root;
		endfunction

		function void queue_quantity(idx_t id, longint unsigned value, logic last);
			quantity_t q;
			q.id = id;
			q.value = ACC_W'(value);
			q.last = last;
			pending.insert(pending.size(), q);
		endfunction

		// accumulate one accepted sample set, queue the report if it closes the window
		function void add_sample(logic [SAMPLE_BITS-1:0] va, logic [SAMPLE_BITS-1:0] vb,
				logic [SAMPLE_BITS-1:0] vc, logic [SAMPLE_BITS-1:0] ia,
				logic [SAMPLE_BITS-1:0] ib, logic [SAMPLE_BITS-1:0] ic);
			longint v[3];
			longint c[3];
			longint line[3];
			longint resid_v;
			longint resid_i;
			longint pwr;
			longint pwr_total;
			longint n;
			int     win;
			sample_total++;
			v[0] = longint'($signed(va));
			v[1] = longint'($signed(vb));
			v[2] = longint'($signed(vc));
			c[0] = longint'($signed(ia));
			c[1] = longint'($signed(ib));
			c[2] = longint'($signed(ic));
			line[0] = v[0] - v[1];
			line[1] = v[1] - v[2];
			line[2] = v[2] - v[0];
			resid_v = v[0] + v[1] + v[2];
			resid_i = c[0] + c[1] + c[2];
			for (int i = 0; i < 3; i++) begin
				phase_sq[i] = phase_sq[i] + PHASE_W'(v[i] * v[i]);
				phase_sq[3 + i] = phase_sq[3 + i] + PHASE_W'(c[i] * c[i]);
				line_sq[i] = line_sq[i] + LINE_W'(line[i] * line[i]);
				power_acc[i] = power_acc[i] + POWER_W'(v[i] * c[i]);
			end
			resid_sq[0] = resid_sq[0] + RESID_W'(resid_v * resid_v);
			resid_sq[1] = resid_sq[1] + RESID_W'(resid_i * resid_i);
			// count saturates while the window stays open
			if (sample_cnt != {COUNT_W{1'b1}}) sample_cnt++;

			win = (window_len > WINDOW_MAX) ? WINDOW_MAX : int'(window_len);
			if (win == 0 || int'(sample_cnt) < win) return;

			// window report, divided by the actual count
			n = longint'(sample_cnt);
			for (int i = 0; i < 6; i++)
				queue_quantity(idx_t'(ID_VRMS_A + i), mean_rms(phase_sq[i], n), 1'b0);
			for (int i = 0; i < 3; i++)
				queue_quantity(idx_t'(ID_VRMS_AB + i), mean_rms(line_sq[i], n), 1'b0);
			pwr_total = 0;
			for (int i = 0; i < 3; i++) begin
				pwr = longint'($signed(power_acc[i]));
				pwr_total += pwr;
				queue_quantity(idx_t'(ID_POWER_A + i), pwr / n, 1'b0);
			end
			queue_quantity(ID_TOTAL, pwr_total / n, 1'b0);
			queue_quantity(ID_RESID_V, resid_sq[0], 1'b0);
			queue_quantity(ID_RESID_I, resid_sq[1], 1'b1);
			report_cnt++;
			clear_sums();
		endfunction

		// compare one accepted result with the oldest queued quantity
		function void compare_quantity(idx_t id, logic [ACC_W-1:0] value, logic last);
			quantity_t want;
			quantity_cnt++;
			if (pending.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTED)
					$display("%0t: result id %0d value %0d arrived with none expected",
						$time, id, $signed(value));
				return;
			end
			want = pending[0];
			pending.delete(0);
			if (id !== want.id) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTED)
					$display("%0t: quantity_id expected %0d actual %0d", $time, want.id, id);
			end
			if (value !== want.value) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTED)
					$display("%0t: quantity_value of id %0d expected %0d actual %0d", $time,
						want.id, $signed(want.value), $signed(value));
			end
			if (last !== want.last) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTED)
					$display("%0t: last_of_window of id %0d expected %0b actual %0b", $time,
						want.id, want.last, last);
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [SAMPLE_BITS-1:0] volt_a;
	logic [SAMPLE_BITS-1:0] volt_b;
	logic [SAMPLE_BITS-1:0] volt_c;
	logic [SAMPLE_BITS-1:0] amp_a;
	logic [SAMPLE_BITS-1:0] amp_b;
	logic [SAMPLE_BITS-1:0] amp_c;
	logic                   out_valid;
	logic                   out_stall;
	logic [ID_W-1:0]        quantity_id;
	logic [ACC_W-1:0]       quantity_value;
	logic                   last_of_window;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_W-1:0]       cfg_data;

	window_report_check meter = new();
	bit                 send_gaps = 1'b1;
	bit                 stall_on  = 1'b1;
	int                 stall_left = 0;
	int                 cycle_cnt = 0;

	three_phase_rms_power_meter dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.volt_a         (volt_a),
		.volt_b         (volt_b),
		.volt_c         (volt_c),
		.amp_a          (amp_a),
		.amp_b          (amp_b),
		.amp_c          (amp_c),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.quantity_id    (quantity_id),
		.quantity_value (quantity_value),
		.last_of_window (last_of_window),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	// clock
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			meter.compare_quantity(quantity_id, quantity_value, last_of_window);
	end

	// receiver stalls in random bursts
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (stall_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 15);
			end
		end
	end

	// field value biased toward the extremes
	function automatic logic [SAMPLE_BITS-1:0] rand_field();
		case ($urandom_range(0, 15))
			0, 1:    return 16'h8000;
			2, 3:    return 16'h7fff;
			4:       return 16'h0000;
			5:       return 16'hffff;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// one sample transaction, with an optional idle burst ahead of it
	task automatic drive_sample(input logic [SAMPLE_BITS-1:0] va, input logic [SAMPLE_BITS-1:0] vb,
			input logic [SAMPLE_BITS-1:0] vc, input logic [SAMPLE_BITS-1:0] ia,
			input logic [SAMPLE_BITS-1:0] ib, input logic [SAMPLE_BITS-1:0] ic);
		int gap;
		gap = (send_gaps && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
		if (gap != 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		volt_a <= va;
		volt_b <= vb;
		volt_c <= vc;
		amp_a <= ia;
		amp_b <= ib;
		amp_c <= ic;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		meter.add_sample(va, vb, vc, ia, ib, ic);
		// the accepted set is not offered again
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic send_random();
		drive_sample(rand_field(), rand_field(), rand_field(),
			rand_field(), rand_field(), rand_field());
	endtask

	// drop valid, wait out every queued quantity and the tail of the last sample
	task automatic settle_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (meter.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// window length write transaction
	task automatic set_window(input logic [CFG_W-1:0] len);
		@(negedge clk);
		cfg_data <= len;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		meter.note_window(len);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stimulus
	initial begin
		int               n;
		int               r;
		int               random_items;
		logic [CFG_W-1:0] w;
		arst_n = 1'b0;
		in_valid = 1'b0;
		volt_a = '0;
		volt_b = '0;
		volt_c = '0;
		amp_a = '0;
		amp_b = '0;
		amp_c = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		random_items = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// two windows at the reset length
		repeat (128) send_random();
		settle_block();

		// directed extremes, one report per sample
		set_window(13'd1);
		drive_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		drive_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		drive_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		drive_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
		drive_sample(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
		drive_sample(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
		drive_sample(16'h8000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h0001);
		drive_sample(16'h0001, 16'hffff, 16'h0000, 16'hffff, 16'h0001, 16'h0000);
		drive_sample(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
		drive_sample(16'h8000, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h8000);
		drive_sample(16'h0003, 16'h0000, 16'h0000, 16'h0005, 16'h0000, 16'hfffd);
		repeat (5) send_random();
		settle_block();

		// negative means truncate toward zero
		set_window(13'd2);
		drive_sample(16'h0001, 16'h0001, 16'h0001, 16'hffff, 16'hffff, 16'hffff);
		drive_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		settle_block();

		// closing disabled: no report, the sums keep running
		set_window(13'd0);
		send_gaps = 1'b0;
		for (int i = 0; i < FLOOD_SAMPLES; i++) begin
			r = $urandom_range(0, 9);
			if (r < 8)
				drive_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
			else if (r == 8)
				drive_sample(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
			else
				drive_sample(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		end
		send_gaps = 1'b1;
		settle_block();

		// length above the maximum acts as the maximum
		set_window({CFG_W{1'b1}});
		send_random();
		settle_block();

		// maximum length, then shortened below the count
		set_window(13'(WINDOW_MAX));
		repeat (12) send_random();
		settle_block();
		set_window(13'd5);
		repeat (10) send_random();
		settle_block();

		// random lengths, quiet toward the end
		while (random_items < RANDOM_ITEMS) begin
			if (random_items > RANDOM_ITEMS - 60) begin
				send_gaps = 1'b0;
				stall_on = 1'b0;
			end
			r = $urandom_range(0, 19);
			if (r == 0)
				w = '0;
			else if (r == 1)
				w = 13'(WINDOW_MAX);
			else
				w = 13'($urandom_range(1, 12));
			set_window(w);
			n = $urandom_range(8, 40);
			for (int i = 0; i < n; i++) begin
				// sender holds off until the block has drained
				if (i == n / 2)
					while (meter.pending.size() != 0) @(posedge clk);
				send_random();
			end
			random_items += n;
			settle_block();
		end

		// drain
		@(negedge clk);
		in_valid <= 1'b0;
		while (meter.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d sample sets and %0d window reports (%0d results checked)",
			meter.sample_total, meter.report_cnt, meter.quantity_cnt);
		$display("window lengths from disabled through above maximum, and a window cut short");
		if (meter.mismatch_cnt == 0 && meter.pending.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
